[rtl/ttce_pkg.sv]
package ttce_pkg;

   localparam int OP_W    = 2;
   localparam int CHAR_W  = 8;
   localparam int ADDR_W  = 11;
   localparam int CELL_W  = 16;
   localparam int COLOR_W = 8;

   typedef enum logic [OP_W-1:0] {
      OP_PUT   = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_SPARE = 2'd3
   } op_type;

   localparam logic [CHAR_W-1:0] CHAR_BS  = 8'h08;
   localparam logic [CHAR_W-1:0] CHAR_TAB = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_LF  = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_CR  = 8'h0D;
   localparam logic [CHAR_W-1:0] PRINT_LO = 8'h20;
   localparam logic [CHAR_W-1:0] PRINT_HI = 8'h7F;

   typedef enum logic [2:0] {
      KIND_PRINT = 3'd0,
      KIND_BS    = 3'd1,
      KIND_TAB   = 3'd2,
      KIND_CR    = 3'd3,
      KIND_LF    = 3'd4,
      KIND_READ  = 3'd5,
      KIND_CLEAR = 3'd6,
      KIND_NONE  = 3'd7
   } kind_type;

   typedef struct packed {
      kind_type            kind;
      logic [CHAR_W-1:0]   char_code;
      logic [ADDR_W-1:0]   cell_address;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } q_head_type;

   typedef struct packed {
      logic pop;
      logic busy;
   } back_ctl_type;

endpackage

[rtl/ttce_front.sv]
module ttce_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [ttce_pkg::OP_W-1:0]   req_op,
   input  logic [ttce_pkg::CHAR_W-1:0] req_char_code,
   input  logic [ttce_pkg::ADDR_W-1:0] req_cell_address,
   input  ttce_pkg::back_ctl_type      back_ctl,
   output ttce_pkg::q_head_type        q_head
);
   import ttce_pkg::*;

   localparam int DEPTH = 2;

   cmd_type    q_ff [DEPTH];
   cmd_type    cmd_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;

   always_comb begin
      cmd_in.char_code    = req_char_code;
      cmd_in.cell_address = req_cell_address;
      case (req_op)
         OP_PUT: begin
            case (req_char_code)
               CHAR_BS:  cmd_in.kind = KIND_BS;
               CHAR_TAB: cmd_in.kind = KIND_TAB;
               CHAR_CR:  cmd_in.kind = KIND_CR;
               CHAR_LF:  cmd_in.kind = KIND_LF;
               default: begin
                  cmd_in.kind = (req_char_code inside {[PRINT_LO:PRINT_HI]}) ?
                                KIND_PRINT : KIND_NONE;
               end
            endcase
         end
         OP_READ:  cmd_in.kind = KIND_READ;
         OP_CLEAR: cmd_in.kind = KIND_CLEAR;
         default:  cmd_in.kind = KIND_NONE;
      endcase
   end

   assign req_stall = (count_ff == 2'(DEPTH)) || back_ctl.busy;
   assign push      = req_valid && !req_stall;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = back_ctl.pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, back_ctl.pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd_in;
      end
   end

   assign q_head.valid = (count_ff != 2'd0);
   assign q_head.cmd   = q_ff[rd_ptr_ff];

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(DEPTH))
      else $error("Command queue holds more entries than it has.");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      back_ctl.pop |-> count_ff != 2'd0)
      else $error("Command queue popped while empty.");

   a_push_counts: assert property (@(posedge clock) disable iff (reset)
      push && !back_ctl.pop |=> count_ff == $past(count_ff) + 2'd1)
      else $error("Command queue lost an accepted beat.");

endmodule

[rtl/ttce_back.sv]
module ttce_back #(
   parameter int SCREEN_COLUMNS = 80,
   parameter int SCREEN_ROWS    = 25,
   parameter int TAB_STOP       = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  ttce_pkg::q_head_type         q_head,
   output ttce_pkg::back_ctl_type       back_ctl,
   input  logic                        csr_wr_en,
   input  logic [ttce_pkg::COLOR_W-1:0] csr_wr_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [ttce_pkg::ADDR_W-1:0]  rsp_cursor_location,
   output logic [ttce_pkg::CELL_W-1:0]  rsp_cell_value,
   output logic                        rsp_scrolled
);
   import ttce_pkg::*;

   localparam int CELL_COUNT = SCREEN_COLUMNS * SCREEN_ROWS;
   localparam int LOC_W      = $clog2(CELL_COUNT);
   localparam int LOC_X      = LOC_W + 1;
   localparam int CMP_W      = (ADDR_W > LOC_X) ? ADDR_W : LOC_X;
   localparam int COL_W      = $clog2(SCREEN_COLUMNS);
   localparam int TC_W       = $clog2(SCREEN_COLUMNS + TAB_STOP);
   localparam int ROW_W      = $clog2(SCREEN_ROWS);
   localparam int PH_W       = $clog2(TAB_STOP);

   localparam logic [LOC_W-1:0] LAST_CELL  = LOC_W'(CELL_COUNT - 1);
   localparam logic [LOC_W-1:0] BOTTOM_LOC = LOC_W'((SCREEN_ROWS - 1) * SCREEN_COLUMNS);
   localparam logic [LOC_W-1:0] COLS_LOC   = LOC_W'(SCREEN_COLUMNS);
   localparam logic [TC_W-1:0]  COLS_TC    = TC_W'(SCREEN_COLUMNS);
   localparam logic [TC_W-1:0]  TAB_TC     = TC_W'(TAB_STOP);
   localparam logic [ROW_W-1:0] LAST_ROW   = ROW_W'(SCREEN_ROWS - 1);
   localparam logic [PH_W-1:0]  LAST_PH    = PH_W'(TAB_STOP - 1);

   localparam logic [CELL_W-1:0]  BLANK_CELL  = 16'h0720;
   localparam logic [COLOR_W-1:0] COLOR_RESET = 8'h07;

   typedef enum logic [5:0] {
      S_INIT   = 6'b000001,
      S_IDLE   = 6'b000010,
      S_EXEC   = 6'b000100,
      S_SCROLL = 6'b001000,
      S_CLEAR  = 6'b010000,
      S_DONE   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [CELL_W-1:0]  cells_ff [CELL_COUNT];
   logic [CELL_W-1:0]  rd_data_ff;

   cmd_type            cmd_ff;
   logic [COLOR_W-1:0] color_ff;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [LOC_W-1:0]   loc_ff, loc_in;
   logic [PH_W-1:0]    phase_ff, phase_in;
   logic [LOC_W-1:0]   sweep_ff, sweep_in;
   logic               pend_ff;
   logic [LOC_W-1:0]   pend_addr_ff;
   logic               pend_blank_ff;
   logic               rd_ok_ff;
   logic               scroll_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]  rsp_loc_ff;
   logic [CELL_W-1:0]  rsp_value_ff;
   logic               rsp_scrolled_ff;

   logic [TC_W-1:0]    tab_col, col_inc;
   logic               newline, scroll;
   logic [LOC_X-1:0]   src;
   logic               src_ok, addr_ok, out_free, pop, load_rsp, sweep_last;
   logic               mem_we, mem_re;
   logic [LOC_W-1:0]   mem_waddr, mem_raddr;
   logic [CELL_W-1:0]  mem_wdata;

   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      loc_in   = loc_ff;
      phase_in = phase_ff;
      newline  = 1'b0;
      scroll   = 1'b0;
      tab_col  = TC_W'(col_ff) + TAB_TC - TC_W'(phase_ff);
      col_inc  = TC_W'(col_ff) + TC_W'(1);
      case (cmd_ff.kind)
         KIND_PRINT: begin
            if (col_inc >= COLS_TC) begin
               newline = 1'b1;
            end else begin
               col_in   = col_ff + COL_W'(1);
               loc_in   = loc_ff + LOC_W'(1);
               phase_in = (phase_ff == LAST_PH) ? '0 : phase_ff + PH_W'(1);
            end
         end
         KIND_BS: begin
            if (col_ff != '0) begin
               col_in   = col_ff - COL_W'(1);
               loc_in   = loc_ff - LOC_W'(1);
               phase_in = (phase_ff == '0) ? LAST_PH : phase_ff - PH_W'(1);
            end
         end
         KIND_TAB: begin
            if (tab_col >= COLS_TC) begin
               newline = 1'b1;
            end else begin
               col_in   = COL_W'(tab_col);
               loc_in   = loc_ff + LOC_W'(tab_col - TC_W'(col_ff));
               phase_in = '0;
            end
         end
         KIND_CR: begin
            col_in   = '0;
            loc_in   = loc_ff - LOC_W'(col_ff);
            phase_in = '0;
         end
         KIND_LF: begin
            newline = 1'b1;
         end
         KIND_CLEAR: begin
            col_in   = '0;
            row_in   = '0;
            loc_in   = '0;
            phase_in = '0;
         end
         default: begin
         end
      endcase
      if (newline) begin
         col_in   = '0;
         phase_in = '0;
         if (row_ff == LAST_ROW) begin
            scroll = 1'b1;
            loc_in = BOTTOM_LOC;
         end else begin
            row_in = row_ff + ROW_W'(1);
            loc_in = loc_ff - LOC_W'(col_ff) + COLS_LOC;
         end
      end
   end

   assign src        = LOC_X'(sweep_ff) + LOC_X'(SCREEN_COLUMNS);
   assign src_ok     = src < LOC_X'(CELL_COUNT);
   assign addr_ok    = CMP_W'(cmd_ff.cell_address) < CMP_W'(CELL_COUNT);
   assign sweep_last = (sweep_ff == LAST_CELL);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign load_rsp   = (state_ff == S_DONE) && out_free;
   assign pop        = q_head.valid && ((state_ff == S_IDLE) || load_rsp);

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = sweep_ff;
      mem_wdata = BLANK_CELL;
      mem_re    = 1'b0;
      mem_raddr = src[LOC_W-1:0];
      if (pend_ff) begin
         mem_we    = 1'b1;
         mem_waddr = pend_addr_ff;
         mem_wdata = pend_blank_ff ? BLANK_CELL : rd_data_ff;
      end else if ((state_ff == S_EXEC) && (cmd_ff.kind == KIND_PRINT)) begin
         mem_we    = 1'b1;
         mem_waddr = loc_ff;
         mem_wdata = {color_ff, cmd_ff.char_code};
      end else if ((state_ff == S_INIT) || (state_ff == S_CLEAR)) begin
         mem_we = 1'b1;
      end
      if ((state_ff == S_EXEC) && (cmd_ff.kind == KIND_READ) && addr_ok) begin
         mem_re    = 1'b1;
         mem_raddr = LOC_W'(cmd_ff.cell_address);
      end else if ((state_ff == S_SCROLL) && src_ok) begin
         mem_re = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cells_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= cells_ff[mem_raddr];
      end
   end

   always_comb begin
      state_in = state_ff;
      sweep_in = sweep_ff;
      case (state_ff)
         S_INIT: begin
            sweep_in = sweep_ff + LOC_W'(1);
            if (sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (q_head.valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            sweep_in = '0;
            if (cmd_ff.kind == KIND_CLEAR) begin
               state_in = S_CLEAR;
            end else if (scroll) begin
               state_in = S_SCROLL;
            end else begin
               state_in = S_DONE;
            end
         end
         S_SCROLL, S_CLEAR: begin
            sweep_in = sweep_ff + LOC_W'(1);
            if (sweep_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = q_head.valid ? S_EXEC : S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
            sweep_in = '0;
         end
      endcase
   end

   always_comb begin
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         sweep_ff     <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         loc_ff       <= '0;
         phase_ff     <= '0;
         pend_ff      <= 1'b0;
         color_ff     <= COLOR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         pend_ff      <= (state_ff == S_SCROLL);
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == S_EXEC) begin
            col_ff   <= col_in;
            row_ff   <= row_in;
            loc_ff   <= loc_in;
            phase_ff <= phase_in;
         end
         if (csr_wr_en) begin
            color_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff  <= sweep_ff;
      pend_blank_ff <= !src_ok;
      if (pop) begin
         cmd_ff <= q_head.cmd;
      end
      if (state_ff == S_EXEC) begin
         rd_ok_ff  <= (cmd_ff.kind == KIND_READ) && addr_ok;
         scroll_ff <= scroll;
      end
      if (load_rsp) begin
         rsp_loc_ff      <= ADDR_W'(loc_ff);
         rsp_value_ff    <= rd_ok_ff ? rd_data_ff : '0;
         rsp_scrolled_ff <= scroll_ff;
      end
   end

   assign back_ctl.pop         = pop;
   assign back_ctl.busy        = (state_ff == S_INIT);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_cursor_location  = rsp_loc_ff;
   assign rsp_cell_value       = rsp_value_ff;
   assign rsp_scrolled         = rsp_scrolled_ff;

   a_loc_matches: assert property (@(posedge clock) disable iff (reset)
      int'(loc_ff) == int'(row_ff) * SCREEN_COLUMNS + int'(col_ff))
      else $error("Linear cursor location disagrees with row and column.");

   a_phase_matches: assert property (@(posedge clock) disable iff (reset)
      int'(phase_ff) == int'(col_ff) % TAB_STOP)
      else $error("Tab phase disagrees with cursor column.");

   a_pop_state: assert property (@(posedge clock) disable iff (reset)
      pop |-> (state_ff == S_IDLE) || (state_ff == S_DONE))
      else $error("Command taken while the engine is busy.");

   a_scroll_cursor: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCROLL |-> (row_ff == LAST_ROW) && (col_ff == '0))
      else $error("Cursor not homed on the bottom row during a scroll.");

endmodule

[rtl/text_terminal_char_engine.sv]
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  req_op, req_char_code, req_cell_address
// rsp       out        rsp_valid/rsp_stall  rsp_cursor_location, rsp_cell_value, rsp_scrolled
// csr       in         csr_wr_en            csr_wr_data (text color)
//
// An ordinary beat passes through the cell sequencer's execute state and then its done state,
// which loads the result register and also takes the next queued command.
// A scroll or a clear sweeps the whole cell memory through its single write port.
// After reset a clearing pass blanks every cell of the memory; req_stall stays high
// until it ends.
// A two-entry command queue keeps accepting beats while a result waits on rsp_stall, until it is full.
module text_terminal_char_engine #(
   parameter int SCREEN_COLUMNS = 80,
   parameter int SCREEN_ROWS    = 25,
   parameter int TAB_STOP       = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [ttce_pkg::OP_W-1:0]    req_op,
   input  logic [ttce_pkg::CHAR_W-1:0]  req_char_code,
   input  logic [ttce_pkg::ADDR_W-1:0]  req_cell_address,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [ttce_pkg::ADDR_W-1:0]  rsp_cursor_location,
   output logic [ttce_pkg::CELL_W-1:0]  rsp_cell_value,
   output logic                        rsp_scrolled,
   input  logic                        csr_wr_en,
   input  logic [ttce_pkg::COLOR_W-1:0] csr_wr_data
);
   import ttce_pkg::*;

   q_head_type   q_head;
   back_ctl_type back_ctl;

   ttce_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_char_code    (req_char_code),
      .req_cell_address (req_cell_address),
      .back_ctl         (back_ctl),
      .q_head           (q_head)
   );

   ttce_back #(
      .SCREEN_COLUMNS (SCREEN_COLUMNS),
      .SCREEN_ROWS    (SCREEN_ROWS),
      .TAB_STOP       (TAB_STOP)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .q_head              (q_head),
      .back_ctl            (back_ctl),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_cursor_location (rsp_cursor_location),
      .rsp_cell_value      (rsp_cell_value),
      .rsp_scrolled        (rsp_scrolled)
   );

endmodule
